// ===== rtl/log_band_window_mapper_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the log band window mapper
// Immediate-implication and next-cycle checks clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef LOG_BAND_WINDOW_MAPPER_CORE_DEFINES_SVH
`define LOG_BAND_WINDOW_MAPPER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LBWM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LBWM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LBWM_ASSERT_IMP(lbl, ante, cons, msg)
`define LBWM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/lbwm_pkg.sv =====
// ----------------------------------------------------------------------------
// lbwm_pkg
// Shared constants and codes of the log band window mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package lbwm_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Frequencies are Q16.8 Hz.
    localparam int FREQ_W  = 16;
    localparam int HZ_FRAC = 8;
    localparam int Y_W     = FREQ_W + HZ_FRAC;

    // log2 results: 5 integer bits, 24 fraction bits.
    localparam int K_W      = 5;
    localparam int LOG_FRAC = 24;
    localparam int LOG_W    = K_W + LOG_FRAC;
    localparam int MANT_W   = 31;

    // Split point of the log difference for the edge-target products.
    localparam int DL_SPLIT = 15;

    localparam logic [FREQ_W-1:0] DEF_MIN_HZ = 16'd20;
    localparam logic [FREQ_W-1:0] DEF_MAX_HZ = 16'd20000;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_FREQ = 2'd0,
        CFG_MAX_FREQ = 2'd1,
        CFG_MIN_SPAN = 2'd2
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== rtl/lbwm_log2.sv =====
// ----------------------------------------------------------------------------
// lbwm_log2
// Pipelined log2 of a Q16.8 value: normalize, then one squaring per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lbwm_log2 #(
    parameter int PW = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [lbwm_pkg::Y_W-1:0]    i_y,
    input  logic [PW-1:0]               i_pay,
    output logic                        o_valid,
    output logic [lbwm_pkg::LOG_W-1:0]  o_log,
    output logic [PW-1:0]               o_pay
);

    localparam int NS = lbwm_pkg::LOG_FRAC;
    localparam int MW = lbwm_pkg::MANT_W;
    localparam int LW = lbwm_pkg::LOG_W;
    localparam int KW = lbwm_pkg::K_W;
    localparam int YW = lbwm_pkg::Y_W;

    logic [KW-1:0] k;
    logic [MW-1:0] m0;

    logic          r_v   [0:NS];
    logic [MW-1:0] r_m   [0:NS];
    logic [LW-1:0] r_log [0:NS];
    logic [PW-1:0] r_pay [0:NS];

    // Leading one gives the integer part; the mantissa is left aligned to bit 30.
    always_comb begin
        k = '0;
        for (int b = 0; b < YW; b++) begin
            if (i_y[b]) begin
                k = KW'(b);
            end
        end
        m0 = MW'(i_y) << (KW'(MW - 1) - k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]   <= m0;
            r_log[0] <= {k, {NS{1'b0}}};
            r_pay[0] <= i_pay;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_sq
        logic [2*MW-1:0] sq;
        logic [MW:0]     t;
        logic [MW-1:0]   n_m;
        logic [LW-1:0]   n_log;

        assign sq = r_m[s] * r_m[s];
        assign t  = sq[2*MW-1:MW-1];

        // A square at or above 2.0 yields a one bit and is halved.
        always_comb begin
            n_m   = t[MW] ? t[MW:1] : t[MW-1:0];
            n_log = r_log[s];
            if (t[MW]) begin
                n_log[NS-1-s] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[s+1]   <= n_m;
                r_log[s+1] <= n_log;
                r_pay[s+1] <= r_pay[s];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_log   = r_log[NS];
    assign o_pay   = r_pay[NS];

endmodule

`default_nettype wire

// ===== rtl/lbwm_search.sv =====
// ----------------------------------------------------------------------------
// lbwm_search
// Unrolled binary search for the largest Q16.8 value whose log2 does not exceed a target.
// ----------------------------------------------------------------------------
`default_nettype none

module lbwm_search #(
    parameter int PW = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [lbwm_pkg::Y_W-1:0]    i_ylo,
    input  logic [lbwm_pkg::Y_W-1:0]    i_yhi,
    input  logic [lbwm_pkg::LOG_W-1:0]  i_tgt,
    input  logic [PW-1:0]               i_pay,
    output logic                        o_valid,
    output logic [lbwm_pkg::Y_W-1:0]    o_y,
    output logic [PW-1:0]               o_pay
);

    localparam int YW    = lbwm_pkg::Y_W;
    localparam int LW    = lbwm_pkg::LOG_W;
    localparam int NSTEP = YW;
    localparam int CW    = 1 + 3 * YW + LW + PW;

    logic          s_v   [0:NSTEP-1];
    logic [YW-1:0] s_lo  [0:NSTEP-1];
    logic [YW-1:0] s_hi  [0:NSTEP-1];
    logic [LW-1:0] s_tgt [0:NSTEP-1];
    logic [PW-1:0] s_pay [0:NSTEP-1];

    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        logic          a_v;
        logic [YW-1:0] a_lo, a_hi;
        logic [LW-1:0] a_tgt;
        logic [PW-1:0] a_pay;
        logic [YW:0]   diff1;

        logic          r_mv, r_act;
        logic [YW-1:0] r_mid, r_lo, r_hi;
        logic [LW-1:0] r_tgt;
        logic [PW-1:0] r_pay;

        logic          l_v;
        logic [LW-1:0] l_log;
        logic [CW-1:0] l_pay;
        logic          b_act;
        logic [YW-1:0] b_mid, b_lo, b_hi;
        logic [LW-1:0] b_tgt;
        logic [PW-1:0] b_pay;
        logic          fits;

        if (j == 0) begin : g_first
            assign a_v   = i_valid;
            assign a_lo  = i_ylo;
            assign a_hi  = i_yhi;
            assign a_tgt = i_tgt;
            assign a_pay = i_pay;
        end else begin : g_next
            assign a_v   = s_v[j-1];
            assign a_lo  = s_lo[j-1];
            assign a_hi  = s_hi[j-1];
            assign a_tgt = s_tgt[j-1];
            assign a_pay = s_pay[j-1];
        end

        assign diff1 = {1'b0, a_hi} - {1'b0, a_lo} + (YW+1)'(1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv <= 1'b0;
            end else if (i_en) begin
                r_mv <= a_v;
            end
        end

        // Once the bounds meet, the remaining steps pass the item through.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mid <= a_lo + diff1[YW:1];
                r_act <= (a_lo < a_hi);
                r_lo  <= a_lo;
                r_hi  <= a_hi;
                r_tgt <= a_tgt;
                r_pay <= a_pay;
            end
        end

        lbwm_log2 #(
            .PW (CW)
        ) u_log2 (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (r_mv),
            .i_y     (r_mid),
            .i_pay   ({r_act, r_mid, r_lo, r_hi, r_tgt, r_pay}),
            .o_valid (l_v),
            .o_log   (l_log),
            .o_pay   (l_pay)
        );

        assign {b_act, b_mid, b_lo, b_hi, b_tgt, b_pay} = l_pay;
        assign fits = (l_log <= b_tgt);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_v[j] <= 1'b0;
            end else if (i_en) begin
                s_v[j] <= l_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                s_lo[j]  <= (b_act && fits) ? b_mid : b_lo;
                s_hi[j]  <= (b_act && !fits) ? (b_mid - YW'(1)) : b_hi;
                s_tgt[j] <= b_tgt;
                s_pay[j] <= b_pay;
            end
        end
    end

    assign o_valid = s_v[NSTEP-1];
    assign o_y     = s_lo[NSTEP-1];
    assign o_pay   = s_pay[NSTEP-1];

endmodule

`default_nettype wire

// ===== rtl/lbwm_front.sv =====
// ----------------------------------------------------------------------------
// lbwm_front
// Limit checks, span, window edges and log-domain edge targets.
// ----------------------------------------------------------------------------
`default_nettype none

module lbwm_front #(
    parameter int FRAC_BITS = lbwm_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [FRAC_BITS:0]            i_position,
    input  logic [FRAC_BITS:0]            i_width,
    input  logic [lbwm_pkg::FREQ_W-1:0]   i_min_freq,
    input  logic [lbwm_pkg::FREQ_W-1:0]   i_max_freq,
    input  logic [FRAC_BITS:0]            i_min_span,
    output logic                          o_valid,
    output logic [lbwm_pkg::Y_W-1:0]      o_ylo,
    output logic [lbwm_pkg::Y_W-1:0]      o_yhi,
    output logic [lbwm_pkg::LOG_W-1:0]    o_lt,
    output logic [lbwm_pkg::LOG_W-1:0]    o_rt
);

    localparam int XW  = FRAC_BITS + 1;
    localparam int EW  = FRAC_BITS + 2;
    localparam int SW  = FRAC_BITS + 4;
    localparam int YW  = lbwm_pkg::Y_W;
    localparam int LW  = lbwm_pkg::LOG_W;
    localparam int FW  = lbwm_pkg::FREQ_W;
    localparam int SPL = lbwm_pkg::DL_SPLIT;
    localparam int PPW = LW + EW + 1;
    localparam int SPAN_FLOOR = ((1 << FRAC_BITS) * 5 + 50) / 100;

    localparam logic [XW-1:0] ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [XW-1:0] FLOOR = XW'(SPAN_FLOOR);

    // Stage 1: limits, clamps and the span product.
    logic          bad;
    logic [FW-1:0] fmin, fmax;
    logic [XW-1:0] mw, p, w;

    logic            r1_v;
    logic [YW-1:0]   r1_ymin, r1_ymax;
    logic [XW-1:0]   r1_mw, r1_p;
    logic [2*XW-1:0] r1_prod;

    always_comb begin
        bad  = (i_min_freq < lbwm_pkg::DEF_MIN_HZ) || (i_max_freq <= i_min_freq);
        fmin = bad ? lbwm_pkg::DEF_MIN_HZ : i_min_freq;
        fmax = bad ? lbwm_pkg::DEF_MAX_HZ : i_max_freq;
        if (i_min_span < FLOOR) begin
            mw = FLOOR;
        end else if (i_min_span > ONE) begin
            mw = ONE;
        end else begin
            mw = i_min_span;
        end
        p = (i_position > ONE) ? ONE : i_position;
        w = (i_width > ONE) ? ONE : i_width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ymin <= {fmin, {lbwm_pkg::HZ_FRAC{1'b0}}};
            r1_ymax <= {fmax, {lbwm_pkg::HZ_FRAC{1'b0}}};
            r1_mw   <= mw;
            r1_p    <= p;
            r1_prod <= (ONE - mw) * w;
        end
    end

    // Stage 2: span with half-up rounding.
    logic          r2_v;
    logic [YW-1:0] r2_ymin, r2_ymax;
    logic [XW-1:0] r2_mw, r2_p, r2_span;
    logic [2*XW-1:0] prod_rnd;

    assign prod_rnd = r1_prod + (2*XW)'(ONE >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ymin <= r1_ymin;
            r2_ymax <= r1_ymax;
            r2_mw   <= r1_mw;
            r2_p    <= r1_p;
            r2_span <= r1_mw + XW'(prod_rnd >> FRAC_BITS);
        end
    end

    // Stage 3: edges in half-LSB units, pushed back inside the unit range.
    logic signed [SW-1:0] p2, sp, two, l3, r3;

    logic                 r3_v;
    logic [YW-1:0]        r3_ymin, r3_ymax;
    logic [XW-1:0]        r3_mw;
    logic signed [SW-1:0] r3_l, r3_r;

    always_comb begin
        p2  = $signed(SW'({r2_p, 1'b0}));
        sp  = $signed(SW'(r2_span));
        two = $signed(SW'({ONE, 1'b0}));
        l3  = p2 - sp;
        r3  = p2 + sp;
        if (l3 < 0) begin
            r3 = r3 - l3;
            l3 = '0;
        end
        if (r3 > two) begin
            l3 = l3 - (r3 - two);
            r3 = two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ymin <= r2_ymin;
            r3_ymax <= r2_ymax;
            r3_mw   <= r2_mw;
            r3_l    <= l3;
            r3_r    <= r3;
        end
    end

    // Stage 4: clamp each edge against the minimum span.
    logic signed [SW-1:0] lim_l, lim_r, two4, l4, r4;

    logic          r4_v;
    logic [YW-1:0] r4_ymin, r4_ymax;
    logic [EW-1:0] r4_l, r4_r;

    always_comb begin
        lim_l = $signed(SW'({ONE - r3_mw, 1'b0}));
        lim_r = $signed(SW'({r3_mw, 1'b0}));
        two4  = $signed(SW'({ONE, 1'b0}));
        l4    = r3_l;
        r4    = r3_r;
        if (l4 < 0) begin
            l4 = '0;
        end
        if (l4 > lim_l) begin
            l4 = lim_l;
        end
        if (r4 < lim_r) begin
            r4 = lim_r;
        end
        if (r4 > two4) begin
            r4 = two4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ymin <= r3_ymin;
            r4_ymax <= r3_ymax;
            r4_l    <= EW'(l4);
            r4_r    <= EW'(r4);
        end
    end

    // Band limits in the log domain; each unit carries one edge alongside.
    logic          va, vb;
    logic [LW-1:0] lmin, lmax;
    logic [YW-1:0] a_ymin, b_ymax;
    logic [EW-1:0] a_l, b_r;

    lbwm_log2 #(
        .PW (YW + EW)
    ) u_lmin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r4_v),
        .i_y     (r4_ymin),
        .i_pay   ({r4_ymin, r4_l}),
        .o_valid (va),
        .o_log   (lmin),
        .o_pay   ({a_ymin, a_l})
    );

    lbwm_log2 #(
        .PW (YW + EW)
    ) u_lmax (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r4_v),
        .i_y     (r4_ymax),
        .i_pay   ({r4_ymax, r4_r}),
        .o_valid (vb),
        .o_log   (lmax),
        .o_pay   ({b_ymax, b_r})
    );

    // Stage 5: partial products of the log difference and each edge.
    logic [LW-1:0] dl;
    assign dl = lmax - lmin;

    logic                 r5_v;
    logic [YW-1:0]        r5_ymin, r5_ymax;
    logic [LW-1:0]        r5_lmin;
    logic [SPL+EW-1:0]    r5_pl_lo, r5_pr_lo;
    logic [LW-SPL+EW-1:0] r5_pl_hi, r5_pr_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (i_en) begin
            r5_v <= va & vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ymin  <= a_ymin;
            r5_ymax  <= b_ymax;
            r5_lmin  <= lmin;
            r5_pl_lo <= dl[SPL-1:0] * a_l;
            r5_pl_hi <= dl[LW-1:SPL] * a_l;
            r5_pr_lo <= dl[SPL-1:0] * b_r;
            r5_pr_hi <= dl[LW-1:SPL] * b_r;
        end
    end

    // Stage 6: round and add the lower log limit.
    logic [PPW-1:0] full_l, full_r;

    assign full_l = (PPW'(r5_pl_hi) << SPL) + PPW'(r5_pl_lo) + PPW'(ONE);
    assign full_r = (PPW'(r5_pr_hi) << SPL) + PPW'(r5_pr_lo) + PPW'(ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ylo <= r5_ymin;
            o_yhi <= r5_ymax;
            o_lt  <= r5_lmin + LW'(full_l >> (FRAC_BITS + 1));
            o_rt  <= r5_lmin + LW'(full_r >> (FRAC_BITS + 1));
        end
    end

endmodule

`default_nettype wire

// ===== rtl/log_band_window_mapper_core.sv =====
// ----------------------------------------------------------------------------
// log_band_window_mapper_core
// Maps a window position and width on a log axis to low and high cut frequencies.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transfer when            Payload
//   s_axis    in         tvalid and tready high   position, width (Q1.FRAC_BITS)
//   m_axis    out        tvalid and tready high   low_cut, high_cut (Q16.8 Hz)
//   cfg       in         i_cfg_we high            min_freq, max_freq, min_span
//
// The core is a fully pipelined datapath: one transfer can enter every cycle
// while the pipeline is not held, and each produces exactly one result. A
// result passes through the front end, the low and high edge searches and the
// output register. Each of the 24 binary-search steps is a
// midpoint stage, a log2 pipeline of one normalize and 24 squaring stages, and
// a decision stage.
// Reset is synchronous and active low; it clears all valid bits and loads the
// default band of 20..20000 Hz and the default minimum span.
// The pipeline only stops when its last stage holds a result and the output
// register is full and not being taken; bubbles keep moving otherwise, so new
// inputs are accepted while a finished result waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none
`include "log_band_window_mapper_core_defines.svh"

module log_band_window_mapper_core #(
    parameter int FRAC_BITS = lbwm_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // [FRAC_BITS:0] position, [2*FRAC_BITS+1:FRAC_BITS+1] width, zero pad above
    input  logic [((2*(FRAC_BITS+1)+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [23:0] low_cut, [47:24] high_cut
    output logic [2*lbwm_pkg::Y_W-1:0]       o_m_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  logic                             i_cfg_we,
    input  logic [lbwm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [((FRAC_BITS+1 > lbwm_pkg::FREQ_W) ? FRAC_BITS+1 : lbwm_pkg::FREQ_W)-1:0]
                                             i_cfg_data
);

    localparam int XW = FRAC_BITS + 1;
    localparam int YW = lbwm_pkg::Y_W;
    localparam int LW = lbwm_pkg::LOG_W;
    localparam int FW = lbwm_pkg::FREQ_W;
    localparam int SPAN_FLOOR = ((1 << FRAC_BITS) * 5 + 50) / 100;

    // Configuration registers.
    logic [FW-1:0] r_min_freq, r_max_freq;
    logic [XW-1:0] r_min_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_freq <= lbwm_pkg::DEF_MIN_HZ;
            r_max_freq <= lbwm_pkg::DEF_MAX_HZ;
            r_min_span <= XW'(SPAN_FLOOR);
        end else if (i_cfg_we) begin
            case (lbwm_pkg::t_cfg_idx'(i_cfg_idx))
                lbwm_pkg::CFG_MIN_FREQ: begin
                    r_min_freq <= i_cfg_data[FW-1:0];
                end
                lbwm_pkg::CFG_MAX_FREQ: begin
                    r_max_freq <= i_cfg_data[FW-1:0];
                end
                lbwm_pkg::CFG_MIN_SPAN: begin
                    r_min_span <= i_cfg_data[XW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Global pipeline enable: hold only when the last stage cannot drain.
    logic en;
    logic v_lo, v_hi;
    logic r_out_valid;

    assign en              = !(v_lo && r_out_valid && !i_m_axis_tready);
    assign o_s_axis_tready = en;

    // Front end: limits, span, edges and log targets.
    logic          f_v;
    logic [YW-1:0] f_ylo, f_yhi;
    logic [LW-1:0] f_lt, f_rt;

    lbwm_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_s_axis_tvalid),
        .i_position (i_s_axis_tdata[XW-1:0]),
        .i_width    (i_s_axis_tdata[2*XW-1:XW]),
        .i_min_freq (r_min_freq),
        .i_max_freq (r_max_freq),
        .i_min_span (r_min_span),
        .o_valid    (f_v),
        .o_ylo      (f_ylo),
        .o_yhi      (f_yhi),
        .o_lt       (f_lt),
        .o_rt       (f_rt)
    );

    // Two lanes search the edge frequencies in lockstep; both carry the band top.
    logic [YW-1:0] lo_cut, hi_cut, top_lo, top_hi;

    lbwm_search #(
        .PW (YW)
    ) u_search_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_ylo   (f_ylo),
        .i_yhi   (f_yhi),
        .i_tgt   (f_lt),
        .i_pay   (f_yhi),
        .o_valid (v_lo),
        .o_y     (lo_cut),
        .o_pay   (top_lo)
    );

    lbwm_search #(
        .PW (YW)
    ) u_search_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_ylo   (f_ylo),
        .i_yhi   (f_yhi),
        .i_tgt   (f_rt),
        .i_pay   (f_yhi),
        .o_valid (v_hi),
        .o_y     (hi_cut),
        .o_pay   (top_hi)
    );

    // A collapsed window is opened by one LSB, without passing the band top.
    logic [YW-1:0] n_hi;

    always_comb begin
        n_hi = hi_cut;
        if (hi_cut <= lo_cut) begin
            n_hi = (lo_cut >= top_hi) ? top_hi : (lo_cut + YW'(1));
        end
    end

    // Output register.
    logic [YW-1:0] r_out_lo, r_out_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && v_lo) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && v_lo) begin
            r_out_lo <= lo_cut;
            r_out_hi <= n_hi;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_hi, r_out_lo};

    // The two search lanes must stay aligned item for item.
    `LBWM_ASSERT_IMP(a_lane_valid_sync, 1'b1, v_lo == v_hi, "search lanes out of step")
    `LBWM_ASSERT_IMP(a_lane_top_match, v_lo, top_lo == top_hi, "search lanes hold different items")
    // A result never reports the high cut below the low cut.
    `LBWM_ASSERT_IMP(a_cut_order, r_out_valid, r_out_hi >= r_out_lo, "high cut below low cut")
    // A blocked result must stay in the last stage until the output drains.
    `LBWM_ASSERT_NXT(a_stall_hold, v_lo && r_out_valid && !i_m_axis_tready, v_lo,
        "pipeline dropped a stalled result")

endmodule

`default_nettype wire
